// ===== rtl/lrsv_pkg.sv =====
// ----------------------------------------------------------------------------
// lrsv_pkg: shared types and constants for the log record scan validator
// Status codes, header constants and the output beat layout.
// ----------------------------------------------------------------------------
package lrsv_pkg;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_MAGIC = 3'd1,
        ST_TRUNCATED = 3'd2,
        ST_BAD_SUM   = 3'd3,
        ST_CLEAN_END = 3'd4
    } status_t;

    localparam logic [31:0] MAGIC_WORD = 32'h504d3443;
    localparam logic [31:0] FNV_BASIS  = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME  = 32'd16777619;

    // Index of the last byte of the 56-byte header.
    localparam logic [5:0]  HDR_LAST   = 6'd55;

    localparam int OUT_OFF_W = 40;
    localparam int TDATA_W   = 304;

endpackage

// ===== rtl/log_record_scan_validator.sv =====
// ----------------------------------------------------------------------------
// log_record_scan_validator: log segment record checker
// Parses record headers, runs FNV-1a over each record and reports good
// records, errors and segment end on a result stream.
// ----------------------------------------------------------------------------
// Results: the accept edge loads the input register, and the result beat enters the
// result queue when that input beat is processed and the queue has room for it.
// Throughput: one input beat per cycle; a beat that causes one result waits while
// the two-entry result queue is full, one that causes two waits until it is empty.
// Reset: aresetn is synchronous, active low; it empties the input register and the
// result queue and returns the parser to the start of a segment at offset zero.
module log_record_scan_validator
    import lrsv_pkg::*;
#(
    parameter int OFFSET_BITS = 40
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] data_byte
    input  logic                 s_tlast,   // end_of_segment
    input  logic                 s_tuser,   // [0] no_byte

    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [39:0] record_offset, [103:40] hash_val, [167:104] sequence_res,
    // [231:168] expiry_ms, [263:232] key_length, [295:264] value_length,
    // [296] is_tombstone, [303:297] zero
    output logic [TDATA_W-1:0]   m_tdata,
    output logic                 m_tlast,   // final_res
    output logic [2:0]           m_tuser    // [2:0] status
);

    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_KEY    = 3'b010,
        PH_VALUE  = 3'b100
    } phase_t;

    typedef struct packed {
        status_t                status;
        logic [OUT_OFF_W-1:0]   record_offset;
        logic [63:0]            hash_val;
        logic [63:0]            sequence_res;
        logic signed [63:0]     expiry_ms;
        logic [31:0]            key_length;
        logic [31:0]            value_length;
        logic                   is_tombstone;
        logic                   final_res;
    } res_t;

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_eos_reg;
    logic       in_nob_reg;

    // Parser state
    phase_t                 phase_reg, phase_next;
    logic [5:0]             header_index_reg, header_index_next;
    logic [31:0]            remaining_reg, remaining_next;
    logic [31:0]            running_sum_reg, running_sum_next;
    logic [31:0]            checksum_reg, checksum_next;
    logic [31:0]            magic_reg, magic_next;
    logic [63:0]            hash_reg, hash_next;
    logic [63:0]            seq_reg, seq_next;
    logic [63:0]            expiry_reg, expiry_next;
    logic [31:0]            klen_reg, klen_next;
    logic [31:0]            vlen_reg, vlen_next;
    logic                   tomb_reg, tomb_next;
    logic [OUT_OFF_W-1:0]   record_start_reg, record_start_next;
    logic [OFFSET_BITS-1:0] byte_offset_reg, byte_offset_next;
    logic                   halted_reg, halted_next;

    // Result queue
    res_t       q0_reg, q0_next;
    res_t       q1_reg, q1_next;
    logic [1:0] count_reg, count_next;

    logic [31:0] sum_in;
    logic [31:0] mixed;
    logic [31:0] rem_dec;
    logic [63:0] off_ext;
    logic [63:0] off_next_ext;
    logic        finish;
    res_t        res_a, res_b, first_res;
    logic        va, vb;
    logic [1:0]  n_res;
    logic        proc_fire;
    logic        pop;
    logic [1:0]  base_count;
    res_t        s0, s1;

    assign proc_fire = in_valid_reg && ({1'b0, count_reg} + {1'b0, n_res} <= 3'd2);
    assign s_tready  = !in_valid_reg || proc_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_eos_reg  <= s_tlast;
            in_nob_reg  <= s_tuser;
        end
    end

    always_comb begin
        phase_next        = phase_reg;
        header_index_next = header_index_reg;
        remaining_next    = remaining_reg;
        running_sum_next  = running_sum_reg;
        checksum_next     = checksum_reg;
        magic_next        = magic_reg;
        hash_next         = hash_reg;
        seq_next          = seq_reg;
        expiry_next       = expiry_reg;
        klen_next         = klen_reg;
        vlen_next         = vlen_reg;
        tomb_next         = tomb_reg;
        record_start_next = record_start_reg;
        byte_offset_next  = byte_offset_reg;
        halted_next       = halted_reg;
        res_a             = '0;
        res_b             = '0;
        va                = 1'b0;
        vb                = 1'b0;
        finish            = 1'b0;
        rem_dec           = remaining_reg - 32'd1;
        off_ext           = 64'(byte_offset_reg);

        // The sum restarts from the basis on the first header byte.
        sum_in = running_sum_reg;
        if (phase_reg == PH_HEADER && header_index_reg == '0) begin
            sum_in = FNV_BASIS;
        end
        mixed = (sum_in ^ {24'd0, in_byte_reg}) * FNV_PRIME;

        if (!in_nob_reg && !halted_reg) begin
            unique case (phase_reg)
                PH_HEADER: begin
                    if (header_index_reg == '0) begin
                        record_start_next = off_ext[OUT_OFF_W-1:0];
                    end
                    // The checksum field itself is left out of the sum.
                    if (header_index_reg < 6'd4 || header_index_reg > 6'd7) begin
                        running_sum_next = mixed;
                    end
                    if (header_index_reg < 6'd4) begin
                        magic_next[{header_index_reg[1:0], 3'b000} +: 8] = in_byte_reg;
                    end else if (header_index_reg < 6'd8) begin
                        checksum_next[{header_index_reg[1:0], 3'b000} +: 8] = in_byte_reg;
                    end else if (header_index_reg < 6'd16) begin
                        hash_next[{header_index_reg[2:0], 3'b000} +: 8] = in_byte_reg;
                    end else if (header_index_reg < 6'd24) begin
                        seq_next[{header_index_reg[2:0], 3'b000} +: 8] = in_byte_reg;
                    end else if (header_index_reg >= 6'd32 && header_index_reg < 6'd40) begin
                        expiry_next[{header_index_reg[2:0], 3'b000} +: 8] = in_byte_reg;
                    end else if (header_index_reg >= 6'd40 && header_index_reg < 6'd44) begin
                        klen_next[{header_index_reg[1:0], 3'b000} +: 8] = in_byte_reg;
                    end else if (header_index_reg >= 6'd44 && header_index_reg < 6'd48) begin
                        vlen_next[{header_index_reg[1:0], 3'b000} +: 8] = in_byte_reg;
                    end else if (header_index_reg == 6'd48) begin
                        tomb_next = |in_byte_reg;
                    end
                    header_index_next = header_index_reg + 6'd1;
                    if (header_index_reg == HDR_LAST) begin
                        header_index_next = '0;
                        if (magic_reg != MAGIC_WORD) begin
                            va                  = 1'b1;
                            res_a.status        = ST_BAD_MAGIC;
                            res_a.record_offset = record_start_reg;
                            halted_next         = 1'b1;
                        end else if (klen_reg != '0) begin
                            phase_next     = PH_KEY;
                            remaining_next = klen_reg;
                        end else if (vlen_reg != '0) begin
                            phase_next     = PH_VALUE;
                            remaining_next = vlen_reg;
                        end else begin
                            finish = 1'b1;
                        end
                    end
                end
                default: begin
                    running_sum_next = mixed;
                    remaining_next   = rem_dec;
                    if (rem_dec == '0) begin
                        if (phase_reg == PH_KEY && vlen_reg != '0) begin
                            phase_next     = PH_VALUE;
                            remaining_next = vlen_reg;
                        end else begin
                            finish = 1'b1;
                        end
                    end
                end
            endcase

            if (finish) begin
                phase_next          = PH_HEADER;
                header_index_next   = '0;
                remaining_next      = '0;
                va                  = 1'b1;
                res_a.record_offset = record_start_reg;
                if (mixed == checksum_reg) begin
                    res_a.status       = ST_OK;
                    res_a.hash_val     = hash_reg;
                    res_a.sequence_res = seq_reg;
                    res_a.expiry_ms    = expiry_reg;
                    res_a.key_length   = klen_reg;
                    res_a.value_length = vlen_reg;
                    res_a.is_tombstone = tomb_reg;
                end else begin
                    res_a.status = ST_BAD_SUM;
                    halted_next  = 1'b1;
                end
            end
        end

        if (!in_nob_reg) begin
            byte_offset_next = byte_offset_reg + OFFSET_BITS'(1);
        end
        off_next_ext = 64'(byte_offset_next);

        if (in_eos_reg) begin
            if (!halted_next) begin
                vb = 1'b1;
                if (phase_next == PH_HEADER && header_index_next == '0) begin
                    res_b.status        = ST_CLEAN_END;
                    res_b.record_offset = off_next_ext[OUT_OFF_W-1:0];
                end else begin
                    res_b.status        = ST_TRUNCATED;
                    res_b.record_offset = record_start_next;
                end
            end
            phase_next        = PH_HEADER;
            header_index_next = '0;
            remaining_next    = '0;
            halted_next       = 1'b0;
            byte_offset_next  = '0;
        end

        res_a.final_res = !vb;
        res_b.final_res = 1'b1;
        n_res     = {1'b0, va} + {1'b0, vb};
        first_res = va ? res_a : res_b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_HEADER;
            header_index_reg <= '0;
            remaining_reg    <= '0;
            byte_offset_reg  <= '0;
            halted_reg       <= 1'b0;
        end else if (proc_fire) begin
            phase_reg        <= phase_next;
            header_index_reg <= header_index_next;
            remaining_reg    <= remaining_next;
            byte_offset_reg  <= byte_offset_next;
            halted_reg       <= halted_next;
        end
        if (proc_fire) begin
            running_sum_reg  <= running_sum_next;
            checksum_reg     <= checksum_next;
            magic_reg        <= magic_next;
            hash_reg         <= hash_next;
            seq_reg          <= seq_next;
            expiry_reg       <= expiry_next;
            klen_reg         <= klen_next;
            vlen_reg         <= vlen_next;
            tomb_reg         <= tomb_next;
            record_start_reg <= record_start_next;
        end
    end

    // Two-entry result queue; the head beat is driven from q0.
    assign m_tvalid = (count_reg != 2'd0);
    assign pop      = m_tvalid && m_tready;

    always_comb begin
        base_count = count_reg - {1'b0, pop};
        s0         = pop ? q1_reg : q0_reg;
        s1         = q1_reg;
        q0_next    = s0;
        q1_next    = s1;
        count_next = base_count;
        if (proc_fire && n_res != 2'd0) begin
            if (base_count == 2'd0) begin
                q0_next = first_res;
            end else begin
                q1_next = first_res;
            end
            // Two results only enter an empty queue.
            if (n_res == 2'd2) begin
                q1_next = res_b;
            end
            count_next = base_count + n_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

    assign m_tdata = {7'd0, q0_reg.is_tombstone, q0_reg.value_length, q0_reg.key_length,
                      q0_reg.expiry_ms, q0_reg.sequence_res, q0_reg.hash_val,
                      q0_reg.record_offset};
    assign m_tlast = q0_reg.final_res;
    assign m_tuser = q0_reg.status;

endmodule

// ===== rtl/lrsv_checker.sv =====
// ----------------------------------------------------------------------------
// lrsv_checker: port-level checks for the log record scan validator
// Watches the result stream and is bound to the top level.
// ----------------------------------------------------------------------------
module lrsv_checker
    import lrsv_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata,
    input logic               m_tlast,
    input logic [2:0]         m_tuser
);

    // A stalled result beat holds its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result beat changed while stalled");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser <= ST_CLEAN_END)
        else $error("status code out of range");

    // Only a good record carries header fields.
    a_err_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_OK |-> m_tdata[TDATA_W-1:OUT_OFF_W] == '0)
        else $error("header fields set on a non-good result");

    // A segment-end result is always the last one of its input beat.
    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_CLEAN_END || m_tuser == ST_TRUNCATED) |-> m_tlast)
        else $error("segment-end result not marked last");

endmodule

bind log_record_scan_validator lrsv_checker u_lrsv_checker (.*);

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: regression bench for log_record_scan_validator
// Builds log segments from well-formed records, flawed records, cut-off
// records and raw noise, streams them into the validator a byte per beat,
// and checks every result beat against a bit-exact record parser.
// ----------------------------------------------------------------------------
module tb_top;
    import lrsv_pkg::*;

    typedef enum logic [1:0] {
        PARSE_HDR,
        PARSE_KEY,
        PARSE_VAL
    } parse_phase_t;

    typedef struct {
        status_t     status;
        logic [39:0] offset;
        logic [63:0] hash_val;
        logic [63:0] seq_no;
        logic [63:0] expiry;
        logic [31:0] key_len;
        logic [31:0] val_len;
        logic        tomb;
        logic        last;
    } scan_result_t;

    typedef struct {
        logic [31:0] magic;
        logic [63:0] hash_val;
        logic [63:0] seq_no;
        logic [63:0] next_off;
        logic [63:0] expiry;
        logic [31:0] key_len;
        logic [31:0] val_len;
        logic [7:0]  tomb;
        logic [55:0] fill;
        bit          bad_sum;
    } rec_spec_t;

    // Record parser that mirrors the validator and holds the results still owed.
    class scan_tracker;
        scan_result_t awaited[$];
        int           failures;
        int           predicted;
        int           by_status[5];

        parse_phase_t phase_now;
        int           hdr_idx;
        logic [31:0]  left_cnt;
        logic [31:0]  fnv_acc;
        logic [31:0]  sum_field;
        logic [31:0]  magic_acc;
        logic [31:0]  klen;
        logic [31:0]  vlen;
        logic [63:0]  kh;
        logic [63:0]  sq;
        logic [63:0]  ex;
        logic         tomb;
        logic [39:0]  rec_start;
        logic [39:0]  pos;
        bit           stopped;

        function new();
            failures = 0;
            predicted = 0;
            clear_state();
        endfunction

        function void clear_state();
            phase_now = PARSE_HDR;
            hdr_idx = 0;
            left_cnt = '0;
            fnv_acc = FNV_BASIS;
            sum_field = '0;
            magic_acc = '0;
            klen = '0;
            vlen = '0;
            kh = '0;
            sq = '0;
            ex = '0;
            tomb = 1'b0;
            rec_start = '0;
            pos = '0;
            stopped = 1'b0;
        endfunction

        function void mix(logic [7:0] b);
            fnv_acc = (fnv_acc ^ {24'd0, b}) * FNV_PRIME;
        endfunction

        function void queue_result(status_t st, logic [39:0] off, bit good);
            scan_result_t r;
            r.status = st;
            r.offset = off;
            r.hash_val = good ? kh : '0;
            r.seq_no = good ? sq : '0;
            r.expiry = good ? ex : '0;
            r.key_len = good ? klen : '0;
            r.val_len = good ? vlen : '0;
            r.tomb = good ? tomb : 1'b0;
            r.last = 1'b0;
            awaited = {awaited, r};
            predicted++;
        endfunction

        function void close_record();
            phase_now = PARSE_HDR;
            hdr_idx = 0;
            left_cnt = '0;
            if (fnv_acc == sum_field) begin
                queue_result(ST_OK, rec_start, 1'b1);
            end else begin
                queue_result(ST_BAD_SUM, rec_start, 1'b0);
                stopped = 1'b1;
            end
        endfunction

        function void parse_byte(logic [7:0] b);
            if (phase_now == PARSE_HDR) begin
                if (hdr_idx == 0) begin
                    rec_start = pos;
                    fnv_acc = FNV_BASIS;
                    magic_acc = '0;
                    sum_field = '0;
                    kh = '0;
                    sq = '0;
                    ex = '0;
                    klen = '0;
                    vlen = '0;
                    tomb = 1'b0;
                end
                // The stored checksum bytes are left out of the running sum.
                if (hdr_idx < 4 || hdr_idx > 7)
                    mix(b);
                if (hdr_idx < 4)
                    magic_acc[8*hdr_idx +: 8] = b;
                else if (hdr_idx < 8)
                    sum_field[8*(hdr_idx-4) +: 8] = b;
                else if (hdr_idx < 16)
                    kh[8*(hdr_idx-8) +: 8] = b;
                else if (hdr_idx < 24)
                    sq[8*(hdr_idx-16) +: 8] = b;
                else if (hdr_idx >= 32 && hdr_idx < 40)
                    ex[8*(hdr_idx-32) +: 8] = b;
                else if (hdr_idx >= 40 && hdr_idx < 44)
                    klen[8*(hdr_idx-40) +: 8] = b;
                else if (hdr_idx >= 44 && hdr_idx < 48)
                    vlen[8*(hdr_idx-44) +: 8] = b;
                else if (hdr_idx == 48)
                    tomb = (b != 8'd0);
                if (hdr_idx == int'(HDR_LAST)) begin
                    hdr_idx = 0;
                    if (magic_acc != MAGIC_WORD) begin
                        queue_result(ST_BAD_MAGIC, rec_start, 1'b0);
                        stopped = 1'b1;
                    end else if (klen != 0) begin
                        phase_now = PARSE_KEY;
                        left_cnt = klen;
                    end else if (vlen != 0) begin
                        phase_now = PARSE_VAL;
                        left_cnt = vlen;
                    end else begin
                        close_record();
                    end
                end else begin
                    hdr_idx++;
                end
            end else begin
                mix(b);
                left_cnt--;
                if (left_cnt == 0) begin
                    if (phase_now == PARSE_KEY && vlen != 0) begin
                        phase_now = PARSE_VAL;
                        left_cnt = vlen;
                    end else begin
                        close_record();
                    end
                end
            end
        endfunction

        function void note_beat(logic [7:0] b, logic eos, logic nob);
            int size_before;
            size_before = awaited.size();
            if (!nob) begin
                if (!stopped)
                    parse_byte(b);
                pos++;
            end
            if (eos) begin
                if (!stopped) begin
                    if (phase_now == PARSE_HDR && hdr_idx == 0)
                        queue_result(ST_CLEAN_END, pos, 1'b0);
                    else
                        queue_result(ST_TRUNCATED, rec_start, 1'b0);
                end
                clear_state();
            end
            if (awaited.size() > size_before)
                awaited[awaited.size() - 1].last = 1'b1;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
            if (exp_v !== act_v) begin
                $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v,
                         act_v);
                failures++;
            end
        endfunction

        function void check_result(logic [2:0] st, logic [TDATA_W-1:0] d, logic last_bit);
            scan_result_t e;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual status %0d offset %0h",
                         $time, st, d[39:0]);
                failures++;
                return;
            end
            e = awaited.pop_front();
            by_status[e.status]++;
            compare_field("status", e.status, st);
            compare_field("record_offset", e.offset, d[39:0]);
            compare_field("hash_val", e.hash_val, d[103:40]);
            compare_field("sequence", e.seq_no, d[167:104]);
            compare_field("expiry_ms", e.expiry, d[231:168]);
            compare_field("key_length", e.key_len, d[263:232]);
            compare_field("value_length", e.val_len, d[295:264]);
            compare_field("is_tombstone", e.tomb, d[296]);
            compare_field("pad bits", '0, d[303:297]);
            compare_field("final flag", e.last, last_bit);
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [7:0]         s_tdata;    // [7:0] data_byte
    logic               s_tlast;    // end_of_segment
    logic               s_tuser;    // [0] no_byte
    logic               m_tvalid;
    logic               m_tready;
    // [39:0] record_offset, [103:40] hash_val, [167:104] sequence_res,
    // [231:168] expiry_ms, [263:232] key_length, [295:264] value_length,
    // [296] is_tombstone, [303:297] zero
    logic [TDATA_W-1:0] m_tdata;
    logic               m_tlast;    // final_res
    logic [2:0]         m_tuser;    // [2:0] status

    scan_tracker sb = new();

    logic [7:0] seg_q[$];
    int         burst_left = 0;
    int         hold_requests = 0;
    int         segments = 0;
    int         data_beats = 0;

    log_record_scan_validator uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Input beats are noted before results are checked, all in one process.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_beat(s_tdata, s_tlast, s_tuser);
            if (m_tvalid && m_tready)
                sb.check_result(m_tuser, m_tdata, m_tlast);
        end
    end

    // Result side: runs of always-ready, coin flips, a rotating pattern and
    // sparse acceptance, plus a long hold-off whenever one is requested.
    initial begin : result_sink
        int          mode;
        int          mode_left;
        int          hold_left;
        int          holds_taken;
        logic [15:0] pattern;
        mode = 0;
        mode_left = 0;
        hold_left = 0;
        holds_taken = 0;
        pattern = '1;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (holds_taken < hold_requests) begin
                holds_taken++;
                hold_left = 500;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                    pattern = 16'($urandom);
                end
                mode_left--;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: begin
                        m_tready <= pattern[0];
                        pattern = {pattern[0], pattern[15:1]};
                    end
                    default: m_tready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    task automatic send_beat(input logic [7:0] b, input logic eos, input logic nob);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= eos;
        s_tuser <= nob;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // Streams the built segment, sprinkling byte-less beats that must be ignored.
    // The segment ends either on its last data beat or on a separate end marker.
    task automatic send_segment(input bit end_on_byte);
        for (int i = 0; i < seg_q.size(); i++) begin
            if ($urandom_range(0, 24) == 0)
                send_beat(8'($urandom), 1'b0, 1'b1);
            send_beat(seg_q[i], end_on_byte && (i == seg_q.size() - 1), 1'b0);
            data_beats++;
        end
        if (!end_on_byte || seg_q.size() == 0)
            send_beat(8'($urandom), 1'b1, 1'b1);
        seg_q.delete();
        segments++;
    endtask

    function automatic rec_spec_t random_spec(int max_len);
        rec_spec_t r;
        r.magic = MAGIC_WORD;
        r.hash_val = {$urandom, $urandom};
        r.seq_no = {$urandom, $urandom};
        r.next_off = {$urandom, $urandom};
        r.expiry = ($urandom_range(0, 3) == 0) ? '1 : {$urandom, $urandom};
        r.key_len = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, max_len);
        r.val_len = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, max_len);
        case ($urandom_range(0, 3))
            0: r.tomb = 8'd0;
            1: r.tomb = 8'd1;
            default: r.tomb = 8'($urandom);
        endcase
        r.fill = {$urandom, 24'($urandom)};
        r.bad_sum = 1'b0;
        return r;
    endfunction

    // Adds one record to the segment. A non-negative keep cuts it after that
    // many bytes; only a whole record gets its checksum filled in.
    function automatic void add_record(rec_spec_t r, longint keep);
        logic [447:0] hdr;
        logic [31:0]  sum;
        logic [7:0]   tail[$];
        longint       whole;
        longint       limit;
        whole = 56 + longint'({32'd0, r.key_len}) + longint'({32'd0, r.val_len});
        limit = (keep < 0 || keep > whole) ? whole : keep;
        hdr = {r.fill, r.tomb, r.val_len, r.key_len, r.expiry, r.next_off, r.seq_no,
               r.hash_val, 32'd0, r.magic};
        for (longint i = 56; i < limit; i++)
            tail = {tail, 8'($urandom)};
        if (limit == whole) begin
            sum = FNV_BASIS;
            for (int i = 0; i < 56; i++)
                if (i < 4 || i > 7)
                    sum = (sum ^ {24'd0, hdr[8*i +: 8]}) * FNV_PRIME;
            foreach (tail[i])
                sum = (sum ^ {24'd0, tail[i]}) * FNV_PRIME;
            hdr[63:32] = r.bad_sum ? (sum ^ (32'd1 << $urandom_range(0, 31))) : sum;
        end
        for (int i = 0; i < 56 && i < limit; i++)
            seg_q = {seg_q, hdr[8*i +: 8]};
        foreach (tail[i])
            seg_q = {seg_q, tail[i]};
    endfunction

    // Mostly chains of valid records; some carry a flaw or get cut short,
    // and a few segments are plain noise.
    task automatic random_segment();
        int        kind;
        int        n;
        int        flaw_at;
        int        flaw;
        bit        cut;
        rec_spec_t r;
        kind = $urandom_range(0, 99);
        if (kind < 85) begin
            n = $urandom_range(1, 3);
            flaw_at = ($urandom_range(0, 99) < 40) ? $urandom_range(0, n - 1) : -1;
            for (int i = 0; i < n; i++) begin
                r = random_spec(($urandom_range(0, 9) == 0) ? 40 : 8);
                cut = 1'b0;
                if (i == flaw_at) begin
                    flaw = $urandom_range(0, 3);
                    case (flaw)
                        0: r.magic = $urandom_range(0, 1) ? $urandom :
                                     (MAGIC_WORD ^ (32'd1 << $urandom_range(0, 31)));
                        1: r.bad_sum = 1'b1;
                        default: begin
                            cut = 1'b1;
                            if ($urandom_range(0, 1))
                                r.key_len = $urandom;
                        end
                    endcase
                end
                if (cut) begin
                    add_record(r, $urandom_range(1, 70));
                    break;
                end
                add_record(r, -1);
            end
        end else begin
            n = $urandom_range(1, 90);
            if ($urandom_range(0, 1))
                for (int i = 0; i < 4; i++)
                    seg_q = {seg_q, MAGIC_WORD[8*i +: 8]};
            repeat (n) seg_q = {seg_q, 8'($urandom)};
        end
        send_segment(1'($urandom_range(0, 1)));
    endtask

    initial begin
        rec_spec_t r;
        int        seg_idx;
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tlast <= 1'b0;
        s_tuser <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty segment: nothing but an end marker.
        send_segment(1'b0);

        // Header-only records, one with every field at its top value and one all zero.
        r = random_spec(4);
        r.hash_val = '1;
        r.seq_no = '1;
        r.next_off = '1;
        r.expiry = '1;
        r.key_len = 0;
        r.val_len = 0;
        r.tomb = 8'hff;
        r.fill = '1;
        add_record(r, -1);
        r.hash_val = '0;
        r.seq_no = '0;
        r.next_off = '0;
        r.expiry = '0;
        r.tomb = 8'h00;
        r.fill = '0;
        add_record(r, -1);
        send_segment(1'b0);

        // Key only, value only, then both; the last byte also ends the segment.
        r = random_spec(4);
        r.key_len = 3;
        r.val_len = 0;
        add_record(r, -1);
        r = random_spec(4);
        r.key_len = 0;
        r.val_len = 2;
        add_record(r, -1);
        r = random_spec(4);
        r.key_len = 1;
        r.val_len = 4;
        r.tomb = 8'h80;
        add_record(r, -1);
        send_segment(1'b1);

        // Bad magic, then a good record that must be ignored.
        r = random_spec(4);
        r.magic = MAGIC_WORD ^ 32'h8000_0000;
        add_record(r, -1);
        add_record(random_spec(4), -1);
        send_segment(1'b0);

        // Checksum error on the segment's final byte, then bad magic likewise.
        r = random_spec(4);
        r.bad_sum = 1'b1;
        add_record(r, -1);
        send_segment(1'b1);
        r = random_spec(4);
        r.magic = '0;
        add_record(r, -1);
        send_segment(1'b1);

        // Good record, then the segment stops inside the next header.
        add_record(random_spec(4), -1);
        add_record(random_spec(4), 20);
        send_segment(1'b0);

        // A wrong magic inside a cut header still reads as truncated.
        r = random_spec(4);
        r.magic = '0;
        add_record(r, 30);
        send_segment(1'b1);

        // Cut inside a huge key, inside a value, and right after a header.
        r = random_spec(4);
        r.key_len = '1;
        add_record(r, 60);
        send_segment(1'b0);
        r = random_spec(4);
        r.key_len = 2;
        r.val_len = 9;
        add_record(r, 60);
        send_segment(1'b1);
        r = random_spec(4);
        r.key_len = 5;
        add_record(r, 56);
        send_segment(1'b0);
        wait_drained();

        seg_idx = 0;
        while (seg_idx < 2 || data_beats < 750) begin
            if (seg_idx == 0) begin
                // Results are held back while several records keep coming,
                // so the result queue fills and the input side has to stall.
                hold_requests++;
                for (int i = 0; i < 3; i++)
                    add_record(random_spec(2), -1);
                send_segment(1'b0);
            end else begin
                random_segment();
            end
            if (seg_idx % 8 == 6)
                wait_drained();
            seg_idx++;
        end

        wait_drained();
        repeat (10) @(posedge aclk);
        $display("Sent %0d segments with %0d data bytes; results checked: %0d good records,",
                 segments, data_beats, sb.by_status[ST_OK]);
        $display("%0d bad magic, %0d truncated, %0d checksum errors, %0d clean ends.",
                 sb.by_status[ST_BAD_MAGIC], sb.by_status[ST_TRUNCATED],
                 sb.by_status[ST_BAD_SUM], sb.by_status[ST_CLEAN_END]);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("log_record_scan_validator regression: pass");
        else
            $display("log_record_scan_validator regression: fail");
        $finish;
    end

    initial begin
        #2000000;
        $display("Timeout: run limit reached with %0d results outstanding.", sb.pending());
        $display("log_record_scan_validator regression: fail");
        $finish;
    end

endmodule
